>>> rtl/ptm_pkg.sv
// ----------------------------------------------------------------------------
// ptm_pkg
// Field widths, codes and table entry layouts of the pending tag match table.
// ----------------------------------------------------------------------------
package ptm_pkg;

	localparam int TYPE_W     = 2;
	localparam int SEQ_W      = 32;
	localparam int DATA_W     = 48;
	localparam int PLAYER_W   = 8;
	localparam int REASON_W   = 8;
	localparam int MS_W       = 16;
	localparam int PNOW_W     = 5;
	localparam int ANOW_W     = 4;
	localparam int EXP_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [PLAYER_W-1:0] LOCAL_PLAYER_RST = 8'd0;
	localparam logic [MS_W-1:0]     ALERT_LIFE_RST   = 16'd1500;

	typedef enum logic [TYPE_W-1:0] {
		REQ_EXPECT = 2'd0,
		REQ_RESULT = 2'd1,
		REQ_TICK   = 2'd2
	} req_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOCAL_PLAYER = 2'd0,
		REG_ALERT_LIFE   = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic              kind;
		logic [DATA_W-1:0] data;
	} anchor_t;

	typedef struct packed {
		logic [SEQ_W-1:0] tag;
		anchor_t          anchor;
	} pend_entry_t;

	typedef struct packed {
		anchor_t             anchor;
		logic [REASON_W-1:0] code;
		logic [MS_W-1:0]     life;
	} alert_entry_t;

endpackage

>>> rtl/ptm_if.sv
// ----------------------------------------------------------------------------
// ptm_if
// Request, response and configuration channels of the pending tag match table.
// ----------------------------------------------------------------------------
interface ptm_req_if;
	logic                          valid;
	logic                          ready;
	logic [ptm_pkg::TYPE_W-1:0]    req_type;
	logic [ptm_pkg::SEQ_W-1:0]     seq;
	logic                          anchor_kind;
	logic [ptm_pkg::DATA_W-1:0]    anchor_data;
	logic [ptm_pkg::PLAYER_W-1:0]  origin_player;
	logic [ptm_pkg::REASON_W-1:0]  result_reason;
	logic [ptm_pkg::MS_W-1:0]      elapsed_ms;

	modport source (
		output valid, req_type, seq, anchor_kind, anchor_data, origin_player,
		       result_reason, elapsed_ms,
		input  ready
	);
	modport sink (
		input  valid, req_type, seq, anchor_kind, anchor_data, origin_player,
		       result_reason, elapsed_ms,
		output ready
	);
endinterface

interface ptm_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          matched;
	logic                          raised;
	logic                          matched_kind;
	logic [ptm_pkg::DATA_W-1:0]    matched_data;
	logic [ptm_pkg::REASON_W-1:0]  raised_reason;
	logic                          dropped_oldest;
	logic [ptm_pkg::EXP_W-1:0]     expired_count;
	logic [ptm_pkg::PNOW_W-1:0]    pending_now;
	logic [ptm_pkg::ANOW_W-1:0]    alerts_now;

	modport source (
		output valid, matched, raised, matched_kind, matched_data, raised_reason,
		       dropped_oldest, expired_count, pending_now, alerts_now,
		input  ready
	);
	modport sink (
		input  valid, matched, raised, matched_kind, matched_data, raised_reason,
		       dropped_oldest, expired_count, pending_now, alerts_now,
		output ready
	);
endinterface

interface ptm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ptm_pkg::CFG_IDX_W-1:0]   index;
	logic [ptm_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/ptm_ram.sv
// ----------------------------------------------------------------------------
// ptm_ram
// Simple dual-port table memory: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module ptm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/pending_tag_match_table.sv
// ----------------------------------------------------------------------------
// pending_tag_match_table
// Ordered table of outstanding request tags with a second table of timed
// alerts, both held in synchronous memories and compacted by a shift engine.
// An expect appends its tag, shifting the oldest entry out when the table is
// full. A result searches for its tag and shifts the entries behind a hit
// forward; a nonzero reason then raises an alert, evicting the oldest alert
// when that table is full. A tick ages the alerts and drops expired ones.
// One item at a time; the rate is set by the one-entry-per-cycle sweep.
// Reset clears both counts and the control registers; no memory clearing pass.
// ----------------------------------------------------------------------------
module pending_tag_match_table #(
	parameter int PENDING_DEPTH = 16,
	parameter int ALERT_DEPTH   = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	ptm_req_if.sink    req,
	ptm_rsp_if.source  rsp,
	ptm_cfg_if.sink    cfg
);

	localparam int PIW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int PCW = $clog2(PENDING_DEPTH + 1);
	localparam int AIW = (ALERT_DEPTH > 1) ? $clog2(ALERT_DEPTH) : 1;
	localparam int ACW = $clog2(ALERT_DEPTH + 1);
	localparam int PEW = $bits(ptm_pkg::pend_entry_t);
	localparam int AEW = $bits(ptm_pkg::alert_entry_t);

	typedef enum logic [6:0] {
		S_IDLE      = 7'b0000001,
		S_EXP       = 7'b0000010,
		S_P_SEARCH  = 7'b0000100,
		S_P_SHIFT   = 7'b0001000,
		S_A_INS     = 7'b0010000,
		S_A_COMPACT = 7'b0100000,
		S_DONE      = 7'b1000000
	} state_t;

	state_t state_q;

	logic [ptm_pkg::PLAYER_W-1:0] local_player_q;
	logic [ptm_pkg::MS_W-1:0]     alert_life_q;

	logic [ptm_pkg::TYPE_W-1:0]   type_q;
	logic [ptm_pkg::SEQ_W-1:0]    seq_q;
	ptm_pkg::anchor_t             new_anchor_q;
	logic [ptm_pkg::REASON_W-1:0] reason_q;
	logic [ptm_pkg::MS_W-1:0]     elapsed_q;
	ptm_pkg::anchor_t             hit_anchor_q;

	logic [PCW-1:0] pcnt_q;
	logic [ACW-1:0] acnt_q;
	logic [PCW-1:0] p_src_q;
	logic [PCW-1:0] p_dst_q;
	logic           p_pv_s1;
	logic [ACW-1:0] a_src_q;
	logic [ACW-1:0] a_dst_q;
	logic           a_pv_s1;
	logic           evict_q;

	logic           matched_q;
	logic           raised_q;
	logic           dropped_q;
	logic [ACW-1:0] expired_q;

	logic                         rsp_valid_q;
	logic                         rsp_matched_q;
	logic                         rsp_raised_q;
	ptm_pkg::anchor_t             rsp_anchor_q;
	logic [ptm_pkg::REASON_W-1:0] rsp_reason_q;
	logic                         rsp_dropped_q;
	logic [ptm_pkg::EXP_W-1:0]    rsp_expired_q;
	logic [ptm_pkg::PNOW_W-1:0]   rsp_pending_q;
	logic [ptm_pkg::ANOW_W-1:0]   rsp_alerts_q;

	// memory ports
	logic                  p_we;
	logic [PIW-1:0]        p_waddr;
	ptm_pkg::pend_entry_t  p_wdata;
	logic [PEW-1:0]        p_rdata;
	ptm_pkg::pend_entry_t  p_rd;
	logic                  a_we;
	logic [AIW-1:0]        a_waddr;
	ptm_pkg::alert_entry_t a_wdata;
	logic [AEW-1:0]        a_rdata;
	ptm_pkg::alert_entry_t a_rd;

	logic p_issue;
	logic p_hit;
	logic p_full;
	logic a_issue;
	logic a_keep;
	logic a_full;
	logic req_fire;

	ptm_ram #(.WIDTH(PEW), .DEPTH(PENDING_DEPTH)) u_pend_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_src_q[PIW-1:0]),
		.rdata (p_rdata)
	);

	ptm_ram #(.WIDTH(AEW), .DEPTH(ALERT_DEPTH)) u_alert_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.raddr (a_src_q[AIW-1:0]),
		.rdata (a_rdata)
	);

	assign p_rd     = p_rdata;
	assign a_rd     = a_rdata;
	assign p_issue  = (p_src_q < pcnt_q);
	assign a_issue  = (a_src_q < acnt_q);
	assign p_full   = (pcnt_q >= PCW'(PENDING_DEPTH));
	assign a_full   = (acnt_q >= ACW'(ALERT_DEPTH));
	assign p_hit    = p_pv_s1 && (p_rd.tag == seq_q);
	// eviction keeps every entry; a tick keeps what outlives the elapsed time
	assign a_keep   = evict_q || (a_rd.life > elapsed_q);
	assign req_fire = req.valid && req.ready;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// write port steering
	always_comb begin
		p_we    = 1'b0;
		p_waddr = p_dst_q[PIW-1:0];
		p_wdata = p_rd;
		a_we    = 1'b0;
		a_waddr = a_dst_q[AIW-1:0];
		a_wdata = a_rd;
		if (!evict_q) begin
			a_wdata.life = a_rd.life - elapsed_q;
		end
		case (state_q)
			S_EXP: begin
				if (!p_full) begin
					p_we          = 1'b1;
					p_waddr       = pcnt_q[PIW-1:0];
					p_wdata.tag    = seq_q;
					p_wdata.anchor = new_anchor_q;
				end
			end
			S_P_SHIFT: begin
				if (p_pv_s1) begin
					p_we = 1'b1;
				end else if (!p_issue && (type_q == ptm_pkg::REQ_EXPECT)) begin
					// append after the oldest entry has been shifted out
					p_we           = 1'b1;
					p_wdata.tag    = seq_q;
					p_wdata.anchor = new_anchor_q;
				end
			end
			S_A_INS: begin
				if (!a_full) begin
					a_we           = 1'b1;
					a_waddr        = acnt_q[AIW-1:0];
					a_wdata.anchor = hit_anchor_q;
					a_wdata.code   = reason_q;
					a_wdata.life   = alert_life_q;
				end
			end
			S_A_COMPACT: begin
				if (a_pv_s1) begin
					a_we = a_keep;
				end else if (!a_issue && evict_q) begin
					a_we           = 1'b1;
					a_wdata.anchor = hit_anchor_q;
					a_wdata.code   = reason_q;
					a_wdata.life   = alert_life_q;
				end
			end
			default: begin
			end
		endcase
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			local_player_q <= ptm_pkg::LOCAL_PLAYER_RST;
			alert_life_q   <= ptm_pkg::ALERT_LIFE_RST;
			pcnt_q         <= '0;
			acnt_q         <= '0;
			p_src_q        <= '0;
			p_dst_q        <= '0;
			p_pv_s1        <= 1'b0;
			a_src_q        <= '0;
			a_dst_q        <= '0;
			a_pv_s1        <= 1'b0;
			evict_q        <= 1'b0;
			matched_q      <= 1'b0;
			raised_q       <= 1'b0;
			dropped_q      <= 1'b0;
			expired_q      <= '0;
			hit_anchor_q   <= '0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					ptm_pkg::REG_LOCAL_PLAYER: local_player_q <= cfg.data[ptm_pkg::PLAYER_W-1:0];
					ptm_pkg::REG_ALERT_LIFE:   alert_life_q   <= cfg.data[ptm_pkg::MS_W-1:0];
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						matched_q <= 1'b0;
						raised_q  <= 1'b0;
						dropped_q <= 1'b0;
						expired_q <= '0;
						p_src_q   <= '0;
						p_dst_q   <= '0;
						p_pv_s1   <= 1'b0;
						a_src_q   <= '0;
						a_dst_q   <= '0;
						a_pv_s1   <= 1'b0;
						evict_q   <= 1'b0;
						case (req.req_type)
							ptm_pkg::REQ_EXPECT: begin
								state_q <= (req.seq != '0) ? S_EXP : S_DONE;
							end
							ptm_pkg::REQ_RESULT: begin
								state_q <= (req.origin_player == local_player_q) ?
								           S_P_SEARCH : S_DONE;
							end
							ptm_pkg::REQ_TICK: begin
								state_q <= S_A_COMPACT;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_EXP: begin
					if (!p_full) begin
						pcnt_q  <= pcnt_q + PCW'(1);
						state_q <= S_DONE;
					end else begin
						dropped_q <= 1'b1;
						p_src_q   <= PCW'(1);
						p_dst_q   <= '0;
						state_q   <= S_P_SHIFT;
					end
				end
				S_P_SEARCH: begin
					p_pv_s1 <= p_issue;
					if (p_issue) begin
						p_src_q <= p_src_q + PCW'(1);
					end
					if (p_hit) begin
						// drop the read in flight and restart behind the hit
						matched_q    <= 1'b1;
						hit_anchor_q <= p_rd.anchor;
						p_src_q      <= p_dst_q + PCW'(1);
						p_pv_s1      <= 1'b0;
						state_q      <= S_P_SHIFT;
					end else if (p_pv_s1) begin
						p_dst_q <= p_dst_q + PCW'(1);
					end else if (!p_issue) begin
						state_q <= S_DONE;
					end
				end
				S_P_SHIFT: begin
					p_pv_s1 <= p_issue;
					if (p_issue) begin
						p_src_q <= p_src_q + PCW'(1);
					end
					if (p_pv_s1) begin
						p_dst_q <= p_dst_q + PCW'(1);
					end else if (!p_issue) begin
						if (type_q == ptm_pkg::REQ_EXPECT) begin
							state_q <= S_DONE;
						end else begin
							pcnt_q <= pcnt_q - PCW'(1);
							if (reason_q != '0) begin
								raised_q <= 1'b1;
								state_q  <= S_A_INS;
							end else begin
								state_q <= S_DONE;
							end
						end
					end
				end
				S_A_INS: begin
					if (!a_full) begin
						acnt_q  <= acnt_q + ACW'(1);
						state_q <= S_DONE;
					end else begin
						evict_q <= 1'b1;
						a_src_q <= ACW'(1);
						a_dst_q <= '0;
						a_pv_s1 <= 1'b0;
						state_q <= S_A_COMPACT;
					end
				end
				S_A_COMPACT: begin
					a_pv_s1 <= a_issue;
					if (a_issue) begin
						a_src_q <= a_src_q + ACW'(1);
					end
					if (a_pv_s1) begin
						if (a_keep) begin
							a_dst_q <= a_dst_q + ACW'(1);
						end else begin
							expired_q <= expired_q + ACW'(1);
						end
					end else if (!a_issue) begin
						if (!evict_q) begin
							acnt_q <= a_dst_q;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item capture and response payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			type_q            <= req.req_type;
			seq_q             <= req.seq;
			new_anchor_q.kind <= req.anchor_kind;
			new_anchor_q.data <= req.anchor_data;
			reason_q          <= req.result_reason;
			elapsed_q         <= req.elapsed_ms;
		end
		if ((state_q == S_DONE) && (!rsp_valid_q || rsp.ready)) begin
			rsp_matched_q <= matched_q;
			rsp_raised_q  <= raised_q;
			rsp_anchor_q  <= matched_q ? hit_anchor_q : '0;
			rsp_reason_q  <= raised_q ? reason_q : '0;
			rsp_dropped_q <= dropped_q;
			rsp_expired_q <= ptm_pkg::EXP_W'(expired_q);
			rsp_pending_q <= ptm_pkg::PNOW_W'(pcnt_q);
			rsp_alerts_q  <= ptm_pkg::ANOW_W'(acnt_q);
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.matched        = rsp_matched_q;
	assign rsp.raised         = rsp_raised_q;
	assign rsp.matched_kind   = rsp_anchor_q.kind;
	assign rsp.matched_data   = rsp_anchor_q.data;
	assign rsp.raised_reason  = rsp_reason_q;
	assign rsp.dropped_oldest = rsp_dropped_q;
	assign rsp.expired_count  = rsp_expired_q;
	assign rsp.pending_now    = rsp_pending_q;
	assign rsp.alerts_now     = rsp_alerts_q;

	a_pcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q <= PCW'(PENDING_DEPTH))
		else $error("pending count beyond table depth");

	a_acnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acnt_q <= ACW'(ALERT_DEPTH))
		else $error("alert count beyond table depth");

	a_shift_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_P_SHIFT) && p_pv_s1 |-> (p_dst_q < p_src_q))
		else $error("pending shift writes at or ahead of its read pointer");

	a_raise_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.raised |-> rsp.matched)
		else $error("alert raised without a matched entry");

	a_tick_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.expired_count != '0) |-> !rsp.matched && !rsp.dropped_oldest)
		else $error("expiry reported together with a table update");

endmodule
